/* rtl/jjji_pkg.sv */
// Shared types and constants for the joystick joint jog integrator.
// No dependencies; imported by every module of the block.
package jjji_pkg;

    localparam int JOY_BITS_DEF = 12;
    localparam int ANG_W        = 12;
    localparam int CNT_W        = 8;
    localparam int THR_W        = 8;
    localparam int MODE_W       = 3;
    localparam int CFG_IDX_W    = 1;
    localparam int OUT_TDATA_W  = 96;

    localparam int JOY_GAIN     = 10;

    // joint limits, milliradians
    localparam int GRIP_LO  = 1400;
    localparam int GRIP_HI  = 2400;
    localparam int TURN_LO  = 10;
    localparam int TURN_HI  = 3140;
    localparam int SWING_LO = 785;
    localparam int SWING_HI = 2900;
    localparam int ARM_LO   = 0;
    localparam int ARM_HI   = 3140;

    localparam logic [THR_W-1:0] SPIN_THR_RST  = THR_W'(20);
    localparam logic [THR_W-1:0] RESET_THR_RST = THR_W'(5);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SPIN_THR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_THR = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE  = 3'd0,
        MODE_CLAW  = 3'd1,
        MODE_WRIST = 3'd2,
        MODE_ARM   = 3'd3,
        MODE_BASE  = 3'd4
    } t_mode;

    // per-word control for a hold counter
    typedef struct packed {
        logic press;   // count up, check threshold
        logic keep;    // not pressed, but hold the count
    } t_hold_ctl;

endpackage

/* rtl/jjji_jog.sv */
// One joint setpoint: adds gain * stick sample and clamps to [LO, HI].
// Depends on jjji_pkg.
module jjji_jog #(
    parameter int JOY_BITS = jjji_pkg::JOY_BITS_DEF,
    parameter int LO       = jjji_pkg::ARM_LO,
    parameter int HI       = jjji_pkg::ARM_HI
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic signed [JOY_BITS-1:0] i_joy,
    output logic [jjji_pkg::ANG_W-1:0] o_angle
);
    import jjji_pkg::*;

    localparam int SUM_W = JOY_BITS + 6;
    localparam logic signed [SUM_W-1:0] LO_S = SUM_W'(LO);
    localparam logic signed [SUM_W-1:0] HI_S = SUM_W'(HI);

    logic [ANG_W-1:0]        r_angle;
    logic [ANG_W-1:0]        n_angle;
    logic signed [SUM_W-1:0] w_joy;
    logic signed [SUM_W-1:0] w_step;
    logic signed [SUM_W-1:0] w_sum;

    assign w_joy  = SUM_W'(i_joy);
    // x10 as x8 + x2
    assign w_step = (w_joy <<< 3) + (w_joy <<< 1);
    assign w_sum  = $signed({{(SUM_W-ANG_W){1'b0}}, r_angle}) + w_step;

    always_comb begin
        if (w_sum >= HI_S) begin
            n_angle = ANG_W'(HI);
        end else if (w_sum <= LO_S) begin
            n_angle = ANG_W'(LO);
        end else begin
            n_angle = w_sum[ANG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= '0;
        end else if (i_en) begin
            r_angle <= n_angle;
        end
    end

    assign o_angle = r_angle;

endmodule

/* rtl/jjji_hold.sv */
// Saturating hold counter with a sticky request flag.
// Depends on jjji_pkg.
module jjji_hold (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  jjji_pkg::t_hold_ctl        i_ctl,
    input  logic [jjji_pkg::THR_W-1:0] i_thresh,
    output logic                       o_flag
);
    import jjji_pkg::*;

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_flag;
    logic             n_flag;

    always_comb begin
        n_cnt  = r_cnt;
        n_flag = r_flag;
        if (i_ctl.press) begin
            // threshold compares against the count before this word
            if (CNT_W'(r_cnt) > CNT_W'(i_thresh)) begin
                n_flag = 1'b1;
            end
            if (r_cnt != '1) begin
                n_cnt = r_cnt + 1'b1;
            end
        end else if (!i_ctl.keep) begin
            n_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_flag <= 1'b0;
        end else if (i_en) begin
            r_cnt  <= n_cnt;
            r_flag <= n_flag;
        end
    end

    assign o_flag = r_flag;

endmodule

/* rtl/joystick_joint_jog_integrator.sv */
// An accepted word waits in the input register and moves to the setpoint/result
// registers once the output can take it; one word per cycle while the output does
// not stall. The two registers form a two-stage pipeline with full back-pressure.
// Reset (i_rst_n low, synchronous): setpoints, mode, counters and flags to 0,
// thresholds to 20 and 5, both stages empty.
// Top level; depends on jjji_pkg, jjji_jog, jjji_hold.
module joystick_joint_jog_integrator #(
    parameter int JOY_BITS = jjji_pkg::JOY_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [jjji_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [jjji_pkg::THR_W-1:0]         i_cfg_wdata,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // lx, ly, rx, ry (JOY_BITS each), key_one, key_two, key_three, key_four,
    // key_spin, key_reset_a, key_reset_b, zero fill
    input  logic [((4*JOY_BITS+7+7)/8)*8-1:0]  i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // claw_grip, claw_turn, wrist_turn, wrist_swing, upper_arm, fore_arm,
    // base_turn (12 each), active_mode (3), spin_request, reset_request, zero fill
    output logic [jjji_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);
    import jjji_pkg::*;

    localparam int IN_W = ((4*JOY_BITS+7+7)/8)*8;
    localparam int KEY0 = 4*JOY_BITS;

    logic              r_in_valid;
    logic [IN_W-1:0]   r_in_data;
    logic              r_out_valid;
    t_mode             r_mode;
    t_mode             n_mode;
    logic [THR_W-1:0]  r_spin_thr;
    logic [THR_W-1:0]  r_reset_thr;
    logic              w_adv;

    logic signed [JOY_BITS-1:0] w_lx, w_ly, w_rx, w_ry;
    logic w_k1, w_k2, w_k3, w_k4, w_k5, w_k6, w_k7;
    logic w_en_claw, w_en_wrist, w_en_arm, w_en_base;
    t_hold_ctl w_spin_ctl, w_reset_ctl;

    logic [ANG_W-1:0] w_grip, w_claw, w_wturn, w_swing, w_upper, w_fore, w_base;
    logic w_spin_flag, w_reset_flag;

    // pipeline handshake
    assign w_adv           = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_adv;
    assign o_m_axis_tvalid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_data <= i_s_axis_tdata;
        end
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spin_thr  <= SPIN_THR_RST;
            r_reset_thr <= RESET_THR_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                REG_SPIN_THR:  r_spin_thr  <= i_cfg_wdata;
                REG_RESET_THR: r_reset_thr <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // field unpack
    assign w_lx = r_in_data[0*JOY_BITS +: JOY_BITS];
    assign w_ly = r_in_data[1*JOY_BITS +: JOY_BITS];
    assign w_rx = r_in_data[2*JOY_BITS +: JOY_BITS];
    assign w_ry = r_in_data[3*JOY_BITS +: JOY_BITS];
    assign w_k1 = r_in_data[KEY0];
    assign w_k2 = r_in_data[KEY0+1];
    assign w_k3 = r_in_data[KEY0+2];
    assign w_k4 = r_in_data[KEY0+3];
    assign w_k5 = r_in_data[KEY0+4];
    assign w_k6 = r_in_data[KEY0+5];
    assign w_k7 = r_in_data[KEY0+6];

    // priority key decode; keys one to three active high, four active low
    always_comb begin
        if (w_k1) begin
            n_mode = MODE_CLAW;
        end else if (w_k2) begin
            n_mode = MODE_WRIST;
        end else if (w_k3) begin
            n_mode = MODE_ARM;
        end else if (!w_k4) begin
            n_mode = MODE_BASE;
        end else begin
            n_mode = MODE_IDLE;
        end
    end

    always_comb begin
        w_en_claw  = 1'b0;
        w_en_wrist = 1'b0;
        w_en_arm   = 1'b0;
        w_en_base  = 1'b0;
        unique case (n_mode)
            MODE_CLAW:  w_en_claw  = w_adv;
            MODE_WRIST: w_en_wrist = w_adv;
            MODE_ARM:   w_en_arm   = w_adv;
            MODE_BASE:  w_en_base  = w_adv;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
        end else if (w_adv) begin
            r_mode <= n_mode;
        end
    end

    jjji_jog #(.JOY_BITS(JOY_BITS), .LO(GRIP_LO), .HI(GRIP_HI)) u_grip (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en_claw), .i_joy(w_lx), .o_angle(w_grip)
    );
    jjji_jog #(.JOY_BITS(JOY_BITS), .LO(TURN_LO), .HI(TURN_HI)) u_claw (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en_claw), .i_joy(w_rx), .o_angle(w_claw)
    );
    jjji_jog #(.JOY_BITS(JOY_BITS), .LO(TURN_LO), .HI(TURN_HI)) u_wturn (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en_wrist), .i_joy(w_lx), .o_angle(w_wturn)
    );
    jjji_jog #(.JOY_BITS(JOY_BITS), .LO(SWING_LO), .HI(SWING_HI)) u_swing (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en_wrist), .i_joy(w_rx), .o_angle(w_swing)
    );
    jjji_jog #(.JOY_BITS(JOY_BITS), .LO(ARM_LO), .HI(ARM_HI)) u_upper (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en_arm), .i_joy(w_ly), .o_angle(w_upper)
    );
    jjji_jog #(.JOY_BITS(JOY_BITS), .LO(ARM_LO), .HI(ARM_HI)) u_fore (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en_arm), .i_joy(w_ry), .o_angle(w_fore)
    );
    jjji_jog #(.JOY_BITS(JOY_BITS), .LO(TURN_LO), .HI(TURN_HI)) u_base (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en_base), .i_joy(w_rx), .o_angle(w_base)
    );

    // spin and reset keys are active low; reset_b released while reset_a is pressed holds the count
    assign w_spin_ctl.press  = !w_k5;
    assign w_spin_ctl.keep   = 1'b0;
    assign w_reset_ctl.press = !w_k6 && !w_k7;
    assign w_reset_ctl.keep  = !w_k6 && w_k7;

    jjji_hold u_spin_hold (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv), .i_ctl(w_spin_ctl),
        .i_thresh(r_spin_thr), .o_flag(w_spin_flag)
    );
    jjji_hold u_reset_hold (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv), .i_ctl(w_reset_ctl),
        .i_thresh(r_reset_thr), .o_flag(w_reset_flag)
    );

    // the state registers double as the result register
    assign o_m_axis_tdata = {7'b0, w_reset_flag, w_spin_flag, r_mode, w_base, w_fore,
                             w_upper, w_swing, w_wturn, w_claw, w_grip};

    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> r_in_valid)
        else $error("input stalled with empty input register");

    a_spin_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_spin_flag |=> w_spin_flag)
        else $error("spin request cleared without reset");

    a_reset_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_reset_flag |=> w_reset_flag)
        else $error("reset request cleared without reset");

    a_spin_rise_on_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(w_spin_flag) |-> $past(w_adv))
        else $error("spin request set without a word");

    a_base_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_mode == MODE_BASE) |->
            (w_base >= ANG_W'(TURN_LO) && w_base <= ANG_W'(TURN_HI)))
        else $error("base setpoint out of range after base jog");

endmodule
